// File: rtl/arm_ik_pkg.sv
package arm_ik_pkg;

    // Vectoring CORDIC depth and derived pipeline lengths.
    localparam int CORDIC_ITERATIONS = 16;
    localparam int CORDIC_LAT        = CORDIC_ITERATIONS + 4;

    // Square root: radicand and root widths, one root bit per stage.
    localparam int SQ_IN_W  = 60;
    localparam int SQ_OUT_W = SQ_IN_W / 2;
    localparam int SQ_LAT   = SQ_OUT_W;

    // CORDIC widths: input vector, iteration datapath, angle accumulator.
    localparam int CW       = 34;
    localparam int NW       = 32;
    localparam int ZW       = 26;
    localparam int NORM_MSB = 28;

    typedef logic signed [ZW-1:0] t_angle;

    // Half turn in 1/32768 degree.
    localparam t_angle DEG180 = 26'sd5898240;

    // Conversion of 1/32768 degree to 1/128 degree with rounding.
    localparam int ANG_RND   = 128;
    localparam int ANG_SHIFT = 8;

    localparam int SHOULDER_MIN = -46080;
    localparam int SHOULDER_MAX = 23040;
    localparam int ELBOW_MAX    = 23040;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FAR  = 2'd1;
    localparam logic [1:0] ST_NEAR = 2'd2;

    localparam logic [1:0] REG_BASE_X = 2'd0;
    localparam logic [1:0] REG_BASE_Y = 2'd1;
    localparam logic [1:0] REG_UPPER  = 2'd2;
    localparam logic [1:0] REG_LOWER  = 2'd3;

    localparam logic signed [15:0] BASE_X_RST = 16'sd12800;
    localparam logic signed [15:0] BASE_Y_RST = 16'sd1280;
    localparam logic [13:0]        UPPER_RST  = 14'd5824;
    localparam logic [13:0]        LOWER_RST  = 14'd6157;

    typedef struct packed {
        logic signed [16:0] dx;
        logic signed [16:0] dy;
    } t_xy;

    typedef struct packed {
        logic signed [31:0] ns;
        logic signed [31:0] ne;
    } t_nn;

    // atan(2^-i) in 1/32768 degree, rounded to nearest.
    function automatic t_angle atan_lut(input logic [4:0] idx);
        t_angle a;
        case (idx)
            5'd0:  a = 26'sd1474560;
            5'd1:  a = 26'sd870484;
            5'd2:  a = 26'sd459940;
            5'd3:  a = 26'sd233473;
            5'd4:  a = 26'sd117189;
            5'd5:  a = 26'sd58652;
            5'd6:  a = 26'sd29333;
            5'd7:  a = 26'sd14667;
            5'd8:  a = 26'sd7334;
            5'd9:  a = 26'sd3667;
            5'd10: a = 26'sd1833;
            5'd11: a = 26'sd917;
            5'd12: a = 26'sd458;
            5'd13: a = 26'sd229;
            5'd14: a = 26'sd115;
            5'd15: a = 26'sd57;
            5'd16: a = 26'sd29;
            5'd17: a = 26'sd14;
            5'd18: a = 26'sd7;
            5'd19: a = 26'sd4;
            5'd20: a = 26'sd2;
            5'd21: a = 26'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// File: rtl/arm_ik_isqrt.sv
module arm_ik_isqrt import arm_ik_pkg::*; (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [SQ_IN_W-1:0]  i_rad,
    output logic [SQ_OUT_W-1:0] o_root
);

    localparam int RW = SQ_OUT_W + 2;

    logic [SQ_IN_W-1:0]  r_rad  [1:SQ_LAT-1];
    logic [RW-1:0]       r_rem  [1:SQ_LAT-1];
    logic [SQ_OUT_W-1:0] r_root [1:SQ_LAT];

    // Restoring digit recurrence: each stage brings down two radicand bits
    // and decides one root bit.
    for (genvar k = 0; k < SQ_LAT; k++) begin : g_stage
        logic [SQ_IN_W-1:0]  rad_in;
        logic [RW-1:0]       rem_in;
        logic [SQ_OUT_W-1:0] root_in;
        logic [RW+1:0]       rem_sh;
        logic [RW+1:0]       trial;
        logic [RW-1:0]       n_rem;
        logic [SQ_OUT_W-1:0] n_root;

        if (k == 0) begin : g_first
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign rad_in  = r_rad[k];
            assign rem_in  = r_rem[k];
            assign root_in = r_root[k];
        end

        always_comb begin
            rem_sh = {rem_in, rad_in[SQ_IN_W-1 -: 2]};
            trial  = {2'b00, root_in, 2'b01};
            if (rem_sh >= trial) begin
                n_rem  = RW'(rem_sh - trial);
                n_root = {root_in[SQ_OUT_W-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh[RW-1:0];
                n_root = {root_in[SQ_OUT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k+1] <= n_root;
            end
        end

        if (k < SQ_LAT - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad[k+1] <= {rad_in[SQ_IN_W-3:0], 2'b00};
                    r_rem[k+1] <= n_rem;
                end
            end
        end
    end

    assign o_root = r_root[SQ_LAT];

endmodule

// File: rtl/arm_ik_cordic.sv
module arm_ik_cordic import arm_ik_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [CW-1:0] i_x,
    output t_angle               o_z
);

    localparam int PW = $clog2(CW);

    logic signed [CW-1:0] n_fx, n_fy, r_fx, r_fy, r_mx, r_my, r_lx, r_ly;
    t_angle               n_fz, r_fz, r_mz, r_lz;
    logic                 r_fzero, r_mzero, r_lzero;
    logic signed [CW-1:0] mag_y;
    logic [CW-1:0]        n_m, r_m;
    logic [PW-1:0]        n_pos, r_pos;
    logic signed [CW-1:0] n_sx, n_sy;

    logic signed [NW-1:0] r_x    [0:CORDIC_ITERATIONS-1];
    logic signed [NW-1:0] r_y    [0:CORDIC_ITERATIONS-1];
    t_angle               r_z    [0:CORDIC_ITERATIONS];
    logic                 r_zero [0:CORDIC_ITERATIONS];

    // Fold the left half plane onto the right one.
    always_comb begin
        n_fx = i_x;
        n_fy = i_y;
        n_fz = '0;
        if (i_x < 0) begin
            n_fx = -i_x;
            n_fy = -i_y;
            n_fz = (i_y >= 0) ? DEG180 : -DEG180;
        end
    end

    always_comb begin
        mag_y = (r_fy < 0) ? -r_fy : r_fy;
        n_m   = (r_fx > mag_y) ? r_fx : mag_y;
    end

    always_comb begin
        n_pos = '0;
        for (int b = 0; b < CW; b++) begin
            if (r_m[b]) begin
                n_pos = PW'(b);
            end
        end
    end

    // Bring the larger component into [2^28, 2^29); right shifts floor.
    always_comb begin
        if (r_pos > PW'(NORM_MSB)) begin
            n_sx = r_lx >>> (r_pos - PW'(NORM_MSB));
            n_sy = r_ly >>> (r_pos - PW'(NORM_MSB));
        end else begin
            n_sx = r_lx <<< (PW'(NORM_MSB) - r_pos);
            n_sy = r_ly <<< (PW'(NORM_MSB) - r_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fx      <= n_fx;
            r_fy      <= n_fy;
            r_fz      <= n_fz;
            r_fzero   <= (i_x == 0) && (i_y == 0);
            r_mx      <= r_fx;
            r_my      <= r_fy;
            r_mz      <= r_fz;
            r_mzero   <= r_fzero;
            r_m       <= n_m;
            r_lx      <= r_mx;
            r_ly      <= r_my;
            r_lz      <= r_mz;
            r_lzero   <= r_mzero;
            r_pos     <= n_pos;
            r_x[0]    <= n_sx[NW-1:0];
            r_y[0]    <= n_sy[NW-1:0];
            r_z[0]    <= r_lz;
            r_zero[0] <= r_lzero;
        end
    end

    for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_iter
        t_angle n_z;

        always_comb begin
            if (r_y[i] > 0) begin
                n_z = r_z[i] + atan_lut(5'(i));
            end else begin
                n_z = r_z[i] - atan_lut(5'(i));
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_z[i+1]    <= n_z;
                r_zero[i+1] <= r_zero[i];
            end
        end

        if (i < CORDIC_ITERATIONS - 1) begin : g_xy
            logic signed [NW-1:0] ty, tx, n_x, n_y;

            always_comb begin
                ty = r_y[i] >>> i;
                tx = r_x[i] >>> i;
                if (r_y[i] > 0) begin
                    n_x = r_x[i] + ty;
                    n_y = r_y[i] - tx;
                end else begin
                    n_x = r_x[i] - ty;
                    n_y = r_y[i] + tx;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[i+1] <= n_x;
                    r_y[i+1] <= n_y;
                end
            end
        end
    end

    // A zero vector has angle zero.
    assign o_z = r_zero[CORDIC_ITERATIONS] ? '0 : r_z[CORDIC_ITERATIONS];

endmodule

// File: rtl/two_link_arm_inverse_kinematics.sv
// Inverse kinematics of a two-link planar arm.
// Input channel: i_valid / o_stall carry a target point (i_target_x,
// i_target_y, signed Q.8 cm). A request is taken when i_valid is high and
// o_stall is low. Output channel: o_valid / i_stall carry o_status,
// o_shoulder_angle and o_elbow_angle (1/128 degree); a result leaves when
// o_valid is high and i_stall is low. Every request yields one result.
// Throughput is one request per cycle while o_stall is low. The pipeline
// runs offset, squares and radicands, then square root (one root bit per
// stage), then CORDIC (4 setup stages and 16 iterations), then the output
// register. The whole pipeline advances together; while a result waits on
// i_stall the pipeline holds and o_stall is raised, and nothing is lost or
// repeated.
// Configuration writes use i_cfg_valid / o_cfg_ready (always ready) with a
// register index and data; the user must make them while no request is in
// flight, unenforced by the block. Reset restores the default base offset
// and link lengths and empties the pipeline; there is no clearing pass.
module two_link_arm_inverse_kinematics import arm_ik_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_target_x,
    input  logic signed [15:0] i_target_y,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [16:0] o_shoulder_angle,
    output logic [14:0]        o_elbow_angle,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam int NST   = 6 + SQ_LAT + CORDIC_LAT;
    localparam int XY_D  = 5 + SQ_LAT;
    localparam int NN_D  = 2 + SQ_LAT;
    localparam int ST_D  = 2 + SQ_LAT + CORDIC_LAT;

    logic adv;

    logic signed [15:0] r_base_x, r_base_y;
    logic [13:0]        r_upper, r_lower;

    logic [14:0]        n_ulsum;
    logic signed [14:0] n_uld;
    logic signed [29:0] n_diff2;
    logic [29:0]        n_sum2;
    logic [55:0]        n_ul2;
    logic [27:0]        r_u2, r_l2, r_diff2;
    logic [29:0]        r_sum2;
    logic [57:0]        r_ul4;

    logic signed [16:0] n_dx, n_dy, r_dx, r_dy;
    logic signed [33:0] n_dx2, n_dy2;
    logic [31:0]        r_dx2, r_dy2;
    logic [32:0]        r_d2;
    logic [1:0]         n_st, r_st;
    logic signed [34:0] n_ns, n_ne;
    logic signed [31:0] r_ns, r_ne;
    logic [29:0]        r_d2s;
    logic [57:0]        n_p1;
    logic signed [63:0] n_ns2, n_ne2;
    logic [59:0]        r_p1;
    logic [61:0]        r_ns2, r_ne2;
    logic signed [63:0] n_rs, n_re;
    logic [SQ_IN_W-1:0] r_rs, r_re;

    t_xy                r_xy_d [0:XY_D-1];
    t_nn                r_nn_d [0:NN_D-1];
    logic [1:0]         r_st_d [0:ST_D-1];
    logic [NST:1]       r_v;

    logic [SQ_OUT_W-1:0] ss, se;
    t_angle              zb, zi, ze;
    logic signed [CW-1:0] cb_y, cb_x, ci_y, ci_x, ce_y, ce_x;

    logic signed [ZW:0]   n_sh_diff, n_sh_r;
    t_angle               n_el_r;
    logic signed [16:0]   n_sh;
    logic [14:0]          n_el;

    logic               r_ov;
    logic [1:0]         r_status;
    logic signed [16:0] r_sh;
    logic [14:0]        r_el;

    assign adv         = !r_ov || !i_stall;
    assign o_stall     = !adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_x <= BASE_X_RST;
            r_base_y <= BASE_Y_RST;
            r_upper  <= UPPER_RST;
            r_lower  <= LOWER_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BASE_X: r_base_x <= i_cfg_data;
                REG_BASE_Y: r_base_y <= i_cfg_data;
                REG_UPPER:  r_upper  <= i_cfg_data[13:0];
                REG_LOWER:  r_lower  <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // Link-length products are registered (r_ul4 from r_u2 and r_l2), well
    // before a request taken after a write reaches the stages that use them.
    always_comb begin
        n_ulsum = {1'b0, r_upper} + {1'b0, r_lower};
        n_uld   = $signed({1'b0, r_upper}) - $signed({1'b0, r_lower});
        n_sum2  = n_ulsum * n_ulsum;
        n_diff2 = n_uld * n_uld;
        n_ul2   = r_u2 * r_l2;
    end

    always_ff @(posedge i_clk) begin
        r_u2    <= r_upper * r_upper;
        r_l2    <= r_lower * r_lower;
        r_sum2  <= n_sum2;
        r_diff2 <= n_diff2[27:0];
        r_ul4   <= {n_ul2, 2'b00};
    end

    always_comb begin
        n_dx  = {i_target_x[15], i_target_x} - {r_base_x[15], r_base_x};
        n_dy  = {i_target_y[15], i_target_y} - {r_base_y[15], r_base_y};
        n_dx2 = r_dx * r_dx;
        n_dy2 = r_dy * r_dy;

        if (r_d2 > {3'b0, r_sum2}) begin
            n_st = ST_FAR;
        end else if (r_d2 < {5'b0, r_diff2} || r_d2 == '0) begin
            n_st = ST_NEAR;
        end else begin
            n_st = ST_OK;
        end
        n_ns = $signed({7'b0, r_u2}) + $signed({2'b0, r_d2}) - $signed({7'b0, r_l2});
        n_ne = $signed({7'b0, r_l2}) + $signed({7'b0, r_u2}) - $signed({2'b0, r_d2});

        n_p1  = r_u2 * r_d2s;
        n_ns2 = r_ns * r_ns;
        n_ne2 = r_ne * r_ne;

        // Radicands are exact and never negative for a reachable point.
        n_rs = $signed({4'b0, r_p1}) - $signed({2'b0, r_ns2});
        n_re = $signed({6'b0, r_ul4}) - $signed({2'b0, r_ne2});
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dx  <= n_dx;
            r_dy  <= n_dy;
            r_dx2 <= n_dx2[31:0];
            r_dy2 <= n_dy2[31:0];
            r_d2  <= {1'b0, r_dx2} + {1'b0, r_dy2};
            r_st  <= n_st;
            r_ns  <= n_ns[31:0];
            r_ne  <= n_ne[31:0];
            r_d2s <= r_d2[29:0];
            r_p1  <= {n_p1, 2'b00};
            r_ns2 <= n_ns2[61:0];
            r_ne2 <= n_ne2[61:0];
            r_rs  <= n_rs[63] ? '0 : n_rs[SQ_IN_W-1:0];
            r_re  <= n_re[63] ? '0 : n_re[SQ_IN_W-1:0];

            r_xy_d[0] <= '{dx: r_dx, dy: r_dy};
            for (int k = 1; k < XY_D; k++) begin
                r_xy_d[k] <= r_xy_d[k-1];
            end
            r_nn_d[0] <= '{ns: r_ns, ne: r_ne};
            for (int k = 1; k < NN_D; k++) begin
                r_nn_d[k] <= r_nn_d[k-1];
            end
            r_st_d[0] <= r_st;
            for (int k = 1; k < ST_D; k++) begin
                r_st_d[k] <= r_st_d[k-1];
            end
        end
    end

    arm_ik_isqrt u_sqrt_s (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_rad  (r_rs),
        .o_root (ss)
    );

    arm_ik_isqrt u_sqrt_e (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_rad  (r_re),
        .o_root (se)
    );

    assign cb_y = {{(CW-17){r_xy_d[XY_D-1].dy[16]}}, r_xy_d[XY_D-1].dy};
    assign cb_x = {{(CW-17){r_xy_d[XY_D-1].dx[16]}}, r_xy_d[XY_D-1].dx};
    assign ci_y = {{(CW-SQ_OUT_W){1'b0}}, ss};
    assign ci_x = {{(CW-32){r_nn_d[NN_D-1].ns[31]}}, r_nn_d[NN_D-1].ns};
    assign ce_y = {{(CW-SQ_OUT_W){1'b0}}, se};
    assign ce_x = {{(CW-32){r_nn_d[NN_D-1].ne[31]}}, r_nn_d[NN_D-1].ne};

    arm_ik_cordic u_cordic_b (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_y   (cb_y),
        .i_x   (cb_x),
        .o_z   (zb)
    );

    arm_ik_cordic u_cordic_i (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_y   (ci_y),
        .i_x   (ci_x),
        .o_z   (zi)
    );

    arm_ik_cordic u_cordic_e (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_y   (ce_y),
        .i_x   (ce_x),
        .o_z   (ze)
    );

    // The shoulder angle is rounded after the subtraction, then both
    // angles saturate to the joint ranges; both are zero unless ST_OK.
    always_comb begin
        n_sh_diff = {zb[ZW-1], zb} - {zi[ZW-1], zi};
        n_sh_r    = (n_sh_diff + (ZW+1)'(ANG_RND)) >>> ANG_SHIFT;
        n_el_r    = (ze + ZW'(ANG_RND)) >>> ANG_SHIFT;

        if (n_sh_r < SHOULDER_MIN) begin
            n_sh = 17'(SHOULDER_MIN);
        end else if (n_sh_r > SHOULDER_MAX) begin
            n_sh = 17'(SHOULDER_MAX);
        end else begin
            n_sh = n_sh_r[16:0];
        end

        if (n_el_r < 0) begin
            n_el = '0;
        end else if (n_el_r > ELBOW_MAX) begin
            n_el = 15'(ELBOW_MAX);
        end else begin
            n_el = n_el_r[14:0];
        end

        if (r_st_d[ST_D-1] != ST_OK) begin
            n_sh = '0;
            n_el = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_v  <= {r_v[NST-1:1], i_valid};
            r_ov <= r_v[NST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_status <= r_st_d[ST_D-1];
            r_sh     <= n_sh;
            r_el     <= n_el;
        end
    end

    assign o_valid          = r_ov;
    assign o_status         = r_status;
    assign o_shoulder_angle = r_sh;
    assign o_elbow_angle    = r_el;

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_shoulder_angle == 0 && o_elbow_angle == 0))
        else $error("unreachable target carries nonzero angles");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_FAR || o_status == ST_NEAR))
        else $error("status code out of range");

    a_elbow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_elbow_angle <= ELBOW_MAX))
        else $error("elbow angle above limit");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while the output register is empty");

endmodule
